>>> src/tfef_pkg.sv
// ----------------------------------------------------------------------------
// tfef_pkg
// shared types and constants for the tlv frame end finder
// ----------------------------------------------------------------------------
package tfef_pkg;

  localparam int unsigned TagBytes    = 4;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned WordW       = 32;
  localparam int unsigned CountW      = $clog2(HeaderBytes);

  // one result of the parser, as delivered on the output channel
  typedef struct packed {
    logic             frame_done;
    logic [WordW-1:0] frame_end_offset;
    logic             length_error;
  } result_t;

endpackage

>>> src/tfef_parser.sv
// ----------------------------------------------------------------------------
// tfef_parser
// tlv record state: header assembly, value countdown and byte offset
// ----------------------------------------------------------------------------
module tfef_parser
  import tfef_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic [WordW-1:0] end_tag,
  output result_t          result
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_VALUE  = 2'd1,
    PH_HALTED = 2'd2
  } phase_t;

  localparam logic [CountW-1:0] LastHeader = CountW'(HeaderBytes - 1);

  phase_t            phase, phase_next;
  logic [CountW-1:0] header_count, header_count_next;
  logic [WordW-1:0]  record_tag, record_tag_next;
  logic [WordW-1:0]  record_length, record_length_next;
  logic [WordW-2:0]  value_remaining, value_remaining_next;
  logic [WordW-1:0]  consumed_offset, consumed_offset_next;

  always_comb begin
    logic [1:0] lane;
    phase_next           = phase;
    header_count_next    = header_count;
    record_tag_next      = record_tag;
    record_length_next   = record_length;
    value_remaining_next = value_remaining;
    consumed_offset_next = consumed_offset;
    result               = '0;
    lane                 = header_count[1:0];

    case (phase)
      PH_HEADER: begin
        consumed_offset_next = consumed_offset + 1'b1;
        for (int i = 0; i < TagBytes; i++) begin
          if (lane == 2'(i)) begin
            if (header_count < CountW'(TagBytes)) begin
              record_tag_next[8*i +: 8] = data_byte;
            end else begin
              record_length_next[8*i +: 8] = data_byte;
            end
          end
        end
        if (header_count == LastHeader) begin
          header_count_next = '0;
          if (record_length_next[WordW-1]) begin
            // negative length never completes, stop for good
            result.length_error = 1'b1;
            phase_next          = PH_HALTED;
          end else if (record_length_next == '0) begin
            // empty record ends on its last header byte
            if (record_tag_next == end_tag) begin
              result.frame_done       = 1'b1;
              result.frame_end_offset = consumed_offset_next;
            end
          end else begin
            value_remaining_next = record_length_next[WordW-2:0];
            phase_next           = PH_VALUE;
          end
        end else begin
          header_count_next = header_count + 1'b1;
        end
      end
      PH_VALUE: begin
        consumed_offset_next = consumed_offset + 1'b1;
        value_remaining_next = value_remaining - 1'b1;
        if (value_remaining_next == '0) begin
          if (record_tag == end_tag) begin
            result.frame_done       = 1'b1;
            result.frame_end_offset = consumed_offset_next;
          end
          phase_next        = PH_HEADER;
          header_count_next = '0;
        end
      end
      default: begin
        // halted: bytes are dropped, result stays zero
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      record_tag      <= '0;
      record_length   <= '0;
      value_remaining <= '0;
      consumed_offset <= '0;
    end else if (step) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      record_tag      <= record_tag_next;
      record_length   <= record_length_next;
      value_remaining <= value_remaining_next;
      consumed_offset <= consumed_offset_next;
    end
  end

endmodule

>>> src/tlv_frame_end_finder.sv
// ----------------------------------------------------------------------------
// tlv_frame_end_finder
// finds the last byte of the record carrying the end tag in a tlv stream
// ----------------------------------------------------------------------------
// usage:
//   input channel: one stream byte per request on data_byte, handshake
//   in_valid / in_stall. each record is a 4-byte tag and a 4-byte length,
//   little-endian, followed by length value bytes.
//   output channel: exactly one result per input byte (frame_done,
//   frame_end_offset, length_error), handshake out_valid / out_stall.
//   end_tag is written through cfg_we / cfg_wdata while the block is idle.
// pipeline: input register, then result register, with the single parser
//   update between the two; one byte per cycle sustained while the output
//   is not stalled.
// reset (rst, synchronous): both stages empty, parser back in header phase,
//   offset zero, end_tag zero.
// stall: when out_stall holds a full result register, an empty input register
//   still takes one more byte, then in_stall rises until the result drains.
// after a negative length the block reports length_error once and answers
//   every later byte with an all-zero result until reset.
// ----------------------------------------------------------------------------
module tlv_frame_end_finder
  import tfef_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_we,
  input  logic [WordW-1:0] cfg_wdata,
  // byte stream in
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  // results out
  output logic             out_valid,
  input  logic             out_stall,
  output logic             frame_done,
  output logic [WordW-1:0] frame_end_offset,
  output logic             length_error
);

  logic [WordW-1:0] end_tag;

  // input register
  logic             in_full;
  logic [7:0]       in_byte;

  // result register
  result_t          out_result;
  result_t          step_result;

  logic             out_free;
  logic             step;
  logic             in_take;

  // result register can load when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign step     = in_full && out_free;
  // input register frees up when its byte moves on
  assign in_stall = in_full && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_tag <= '0;
    end else if (cfg_we) begin
      end_tag <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= data_byte;
    end
  end

  tfef_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .end_tag   (end_tag),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= step_result;
    end
  end

  assign frame_done       = out_result.frame_done;
  assign frame_end_offset = out_result.frame_end_offset;
  assign length_error     = out_result.length_error;

endmodule

>>> src/tfef_checker.sv
// ----------------------------------------------------------------------------
// tfef_checker
// port-level checks for the tlv frame end finder, bound to the top level
// ----------------------------------------------------------------------------
module tfef_checker
  import tfef_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             frame_done,
  input logic [WordW-1:0] frame_end_offset,
  input logic             length_error
);

  // a byte cannot both end a frame and carry a bad length
  a_done_xor_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_done && length_error))
    else $error("frame_done and length_error together");

  // offset is zero unless the frame is done
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_done) |-> (frame_end_offset == '0))
    else $error("frame_end_offset set without frame_done");

  // input backpressure only comes from a stalled full output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without output backpressure");

  // once the error is delivered, the block stays quiet
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && length_error) |=>
      !(out_valid && (length_error || frame_done)))
    else $error("result after length_error");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(frame_done) && $stable(frame_end_offset)
       && $stable(length_error)))
    else $error("stalled result changed");

endmodule

bind tlv_frame_end_finder tfef_checker u_tfef_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .frame_done       (frame_done),
  .frame_end_offset (frame_end_offset),
  .length_error     (length_error)
);

>>> tb/tlv_frame_end_finder_checker.sv
// ----------------------------------------------------------------------------
// tlv_frame_end_finder_checker
// watches both channels of the tlv frame end finder and checks every result
// ----------------------------------------------------------------------------
// Keeps its own copy of the record parser and of end_tag. Every accepted
// request produces one expected result. Every accepted result is compared
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tlv_frame_end_finder_checker
  import tfef_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [WordW-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             frame_done,
  input  logic [WordW-1:0] frame_end_offset,
  input  logic             length_error,
  output int               mismatches,
  output int               outstanding
);

  localparam int MaxPrinted = 40;

  typedef enum logic [1:0] {PhHeader, PhValue, PhHalted} parse_phase_e;

  parse_phase_e      parse_phase;
  logic [CountW-1:0] hdr_count;
  logic [WordW-1:0]  rec_tag;
  logic [WordW-1:0]  rec_len;
  logic [WordW-2:0]  value_left;
  logic [WordW-1:0]  byte_offset;
  logic [WordW-1:0]  frame_tag;
  result_t           parser_results_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // record complete: flag it when its tag is the end tag
  function automatic void close_record(inout result_t r);
    if (rec_tag == frame_tag) begin
      r.frame_done       = 1'b1;
      r.frame_end_offset = byte_offset;
    end
    parse_phase = PhHeader;
    hdr_count   = '0;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t     r;
    int unsigned n;
    r = '0;
    case (parse_phase)
      PhHeader: begin
        n           = 32'(hdr_count);
        byte_offset = byte_offset + 1'b1;
        if (n < TagBytes) rec_tag[8*n +: 8] = b;
        else rec_len[8*(n-TagBytes) +: 8] = b;
        if (n == HeaderBytes - 1) begin
          hdr_count = '0;
          if (rec_len[WordW-1]) begin
            r.length_error = 1'b1;
            parse_phase    = PhHalted;
          end else if (rec_len == '0) begin
            close_record(r);
          end else begin
            value_left  = rec_len[WordW-2:0];
            parse_phase = PhValue;
          end
        end else begin
          hdr_count = hdr_count + 1'b1;
        end
      end
      PhValue: begin
        byte_offset = byte_offset + 1'b1;
        value_left  = value_left - 1'b1;
        if (value_left == '0) close_record(r);
      end
      default: ; // halted: byte ignored
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    if (mismatches < MaxPrinted)
      $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      parse_phase = PhHeader;
      hdr_count   = '0;
      rec_tag     = '0;
      rec_len     = '0;
      value_left  = '0;
      byte_offset = '0;
      frame_tag   = '0;
      parser_results_q.delete();
    end else begin
      if (cfg_we) frame_tag = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (parser_results_q.size() == 0) begin
          report_mismatch("result with none due, frame_end_offset", frame_end_offset, '0);
        end else begin
          want = parser_results_q.pop_front();
          if (frame_done !== want.frame_done)
            report_mismatch("frame_done", WordW'(frame_done), WordW'(want.frame_done));
          if (frame_end_offset !== want.frame_end_offset)
            report_mismatch("frame_end_offset", frame_end_offset, want.frame_end_offset);
          if (length_error !== want.length_error)
            report_mismatch("length_error", WordW'(length_error),
                            WordW'(want.length_error));
        end
      end
      if (in_valid && !in_stall) parser_results_q.push_back(parse_byte(data_byte));
    end
    outstanding <= parser_results_q.size();
  end

endmodule

>>> tb/tlv_frame_end_finder_test.sv
// ----------------------------------------------------------------------------
// tlv_frame_end_finder_test
// stimulus and verdict for the tlv frame end finder
// ----------------------------------------------------------------------------
// A short directed stream covers the extreme bytes, a zero-length record and
// both tag outcomes. Then come phases of random well-formed records under
// several end_tag settings, with random gaps on the sender and random stalls
// on the receiver. A negative length closes the run, because it halts the
// parser until reset. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module tlv_frame_end_finder_test;
  import tfef_pkg::*;

  localparam int ResetCycles  = 7;
  localparam int SettleCycles = 4;
  localparam int HangLimit    = 2000; // cycles with no handshake at all
  localparam int PhaseBytes   = 165;
  localparam int NumPhases    = 6;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [WordW-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic [7:0]       data_byte = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             frame_done;
  logic [WordW-1:0] frame_end_offset;
  logic             length_error;

  int               mismatches;
  int               outstanding;
  int               idle_cycles = 0;
  int               idle_level  = 0; // 0 none, up to 7: chance in eighths that a burst starts
  logic [WordW-1:0] tag_now     = '0;
  logic [7:0]       stream_q[$];

  always #10 clk = ~clk;

  tlv_frame_end_finder uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .frame_done       (frame_done),
    .frame_end_offset (frame_end_offset),
    .length_error     (length_error)
  );

  tlv_frame_end_finder_checker frame_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .frame_done       (frame_done),
    .frame_end_offset (frame_end_offset),
    .length_error     (length_error),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // hang detection: any handshake on either side restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == HangLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver side: random stall bursts, rate set by idle_level
  initial begin
    forever begin
      @(posedge clk);
      if (idle_level > 0 && $urandom_range(0, 7) < idle_level) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // tag and length bytes, least significant first
  task automatic add_header(input logic [WordW-1:0] tag, input logic [WordW-1:0] len);
    for (int i = 0; i < TagBytes; i++) stream_q.push_back(tag[8*i +: 8]);
    for (int i = 0; i < HeaderBytes - TagBytes; i++) stream_q.push_back(len[8*i +: 8]);
  endtask

  task automatic add_record(input logic [WordW-1:0] tag, input logic [WordW-1:0] len);
    add_header(tag, len);
    for (int j = 0; j < len; j++) stream_q.push_back(8'($urandom));
  endtask

  // mostly the end tag or a near miss of it, so frames close often
  function automatic logic [WordW-1:0] pick_tag();
    logic [WordW-1:0] t;
    t = tag_now;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5:       t = tag_now ^ (32'h1 << $urandom_range(0, 31));
      6:          t[8*$urandom_range(0, 3) +: 8] = 8'($urandom);
      default:    t = $urandom;
    endcase
    return t;
  endfunction

  // short records dominate, a few long ones stretch the value count
  function automatic logic [WordW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return '0;
    if (r < 16) return $urandom_range(1, 12);
    if (r < 19) return $urandom_range(13, 60);
    return $urandom_range(100, 300);
  endfunction

  // each request waits for its handshake; random gaps drop valid between requests
  task automatic send_bytes(input int count);
    for (int i = 0; i < count; i++) begin
      if (idle_level > 0 && $urandom_range(0, 7) < idle_level) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= stream_q.pop_front();
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
  endtask

  // wait until every due result is in, then let the pipeline settle
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_end_tag(input logic [WordW-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tag_now    = value;
  endtask

  initial begin : stimulus
    logic [WordW-1:0] phase_tags[NumPhases];
    int               idle_plan[NumPhases];
    phase_tags = '{32'hFFFF_FFFF, $urandom, 32'h0000_0001, 32'h8000_0000, $urandom, 32'h0};
    idle_plan  = '{3, 1, 0, 5, 2, 0};

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    write_end_tag(32'h0);
    idle_level = 2;

    // zero length on the end tag: frame closes on the last header byte
    add_header(32'h0, 32'h0);
    // all-ones tag misses, one value byte of all ones
    add_header(32'hFFFF_FFFF, 32'h1);
    stream_q.push_back(8'hFF);
    // end tag with two value bytes, alternating bit patterns
    add_header(32'h0, 32'h2);
    stream_q.push_back(8'h5A);
    stream_q.push_back(8'hA5);
    send_bytes(stream_q.size());

    // random records; a phase may stop mid-record, so end_tag also changes
    // while a record is still open in the parser
    for (int p = 0; p < NumPhases; p++) begin
      write_end_tag(phase_tags[p]);
      idle_level = idle_plan[p];
      while (stream_q.size() < PhaseBytes) add_record(pick_tag(), pick_length());
      send_bytes(p == NumPhases - 1 ? stream_q.size() : PhaseBytes);
    end

    // negative length: error once, then every byte is ignored until reset
    add_header($urandom, {1'b1, 31'($urandom)});
    repeat (6) stream_q.push_back(8'($urandom));
    send_bytes(stream_q.size());

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
